// ----- design/hpc_pkg.sv -----
// shared types, constants and ramp helpers for the heightmap palette colorizer
`default_nettype none
package hpc_pkg;

   // field widths
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned RANGE_W  = SAMPLE_W + 1;
   localparam int unsigned COLOR_W  = 8;
   localparam int unsigned KIND_W   = 2;

   // divider: 3 segment bits over 8 weight bits
   localparam int unsigned SEG_W    = 3;
   localparam int unsigned QUOT_W   = SEG_W + COLOR_W;
   localparam int unsigned STEP_W   = 4;

   // product 5*delta needs three extra bits
   localparam int unsigned NUM_W    = SAMPLE_W + 3;

   // running minimum starts above any sample
   localparam logic [RANGE_W-1:0] MIN_RESET = {1'b1, {SAMPLE_W{1'b0}}};
   localparam logic [SAMPLE_W-1:0] MAX_RESET = '0;

   // default depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // request kinds carried on the input tuser
   typedef enum logic [KIND_W-1:0] {
      REQ_CLEAR = 2'd0,
      REQ_SCAN  = 2'd1,
      REQ_MAP   = 2'd2
   } req_kind_type;

   // back part sequencer
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_DONE
   } back_state_type;

   // one map item after classification
   typedef struct packed {
      logic                flat;
      logic [SAMPLE_W-1:0] delta;
      logic [RANGE_W-1:0]  range;
   } job_type;

   // ramp point as on/off per channel: bit 0 red, bit 1 green, bit 2 blue
   function automatic logic [2:0] ramp_point(input logic [SEG_W-1:0] idx);
      logic [2:0] p;
      begin
         case (idx)
            3'd0:    p = 3'b000;
            3'd1:    p = 3'b001;
            3'd2:    p = 3'b011;
            3'd3:    p = 3'b010;
            3'd4:    p = 3'b110;
            3'd5:    p = 3'b100;
            default: p = 3'b000;
         endcase
         return p;
      end
   endfunction

   // blend of two full-or-zero channel values, exact after divide by 255
   function automatic logic [COLOR_W-1:0] blend(input logic p0, input logic p1,
                                                input logic [COLOR_W-1:0] t);
      logic [COLOR_W-1:0] v;
      begin
         case ({p0, p1})
            2'b11:   v = {COLOR_W{1'b1}};
            2'b10:   v = ~t;
            2'b01:   v = t;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

endpackage
`default_nettype wire

// ----- design/hpc_front.sv -----
// front part: accepts items, tracks min/max and classifies map items
`default_nettype none
module hpc_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [hpc_pkg::SAMPLE_W-1:0]    req_tdata,   // sample
   input  wire logic [hpc_pkg::KIND_W-1:0]      req_tuser,   // req_type
   input  wire logic                            queue_full,
   output logic                                 push,
   output hpc_pkg::job_type                     job
);

   logic [hpc_pkg::RANGE_W-1:0]  min_ff, min_in;
   logic [hpc_pkg::SAMPLE_W-1:0] max_ff, max_in;
   logic [hpc_pkg::SAMPLE_W-1:0] min_lo;
   logic [hpc_pkg::SAMPLE_W-1:0] clamped;
   logic                         accept;
   hpc_pkg::req_kind_type        kind;

   assign req_tready = ~queue_full;
   assign accept     = req_tvalid & req_tready;
   assign kind       = hpc_pkg::req_kind_type'(req_tuser);

   // item decode and min/max update
   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      push   = 1'b0;
      if (accept) begin
         case (kind)
            hpc_pkg::REQ_CLEAR: begin
               min_in = hpc_pkg::MIN_RESET;
               max_in = hpc_pkg::MAX_RESET;
            end
            hpc_pkg::REQ_SCAN: begin
               if ({1'b0, req_tdata} < min_ff) begin
                  min_in = {1'b0, req_tdata};
               end
               if (req_tdata > max_ff) begin
                  max_in = req_tdata;
               end
            end
            hpc_pkg::REQ_MAP: begin
               push = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // clamp sample into the scanned span and form offset and range
   assign min_lo = min_ff[hpc_pkg::SAMPLE_W-1:0];

   always_comb begin
      if (req_tdata < min_lo) begin
         clamped = min_lo;
      end else if (req_tdata > max_ff) begin
         clamped = max_ff;
      end else begin
         clamped = req_tdata;
      end
   end

   assign job.flat  = (min_ff >= {1'b0, max_ff});
   assign job.delta = clamped - min_lo;
   assign job.range = {1'b0, max_ff} - min_ff + hpc_pkg::RANGE_W'(1);

   // running extremes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= hpc_pkg::MIN_RESET;
         max_ff <= hpc_pkg::MAX_RESET;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/hpc_queue.sv -----
// small queue of classified map items between front and back
`default_nettype none
module hpc_queue #(
   parameter int unsigned Depth = hpc_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire hpc_pkg::job_type push_job,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output hpc_pkg::job_type      head_job
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   hpc_pkg::job_type     store_ff [Depth];
   logic [PtrW-1:0]      head_ff, head_in;
   logic [PtrW-1:0]      tail_ff, tail_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic                 do_push, do_pop;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_job   = store_ff[head_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   // pointer and fill bookkeeping
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == PtrW'(Depth - 1)) ? '0 : tail_ff + PtrW'(1);
      end
      if (do_pop) begin
         head_in = (head_ff == PtrW'(Depth - 1)) ? '0 : head_ff + PtrW'(1);
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[tail_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

// ----- design/hpc_back.sv -----
// back part: restoring divider for segment and weight, ramp blend, output register
`default_nettype none
module hpc_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              head_valid,
   input  wire hpc_pkg::job_type                  head_job,
   output logic                                   pop,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [3*hpc_pkg::COLOR_W-1:0]          rsp_tdata,   // red, green, blue
   output logic                                   rsp_tuser    // flat
);

   localparam int unsigned RW = hpc_pkg::RANGE_W;
   localparam int unsigned QW = hpc_pkg::QUOT_W;
   localparam int unsigned CW = hpc_pkg::COLOR_W;
   localparam int unsigned SW = hpc_pkg::SEG_W;

   hpc_pkg::back_state_type       state_ff, state_in;
   logic [hpc_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [RW-1:0]                 rem_ff, rem_in;
   logic [QW-1:0]                 dq_ff, dq_in;
   logic [RW-1:0]                 range_ff, range_in;
   logic                          flat_ff, flat_in;
   logic                          out_valid_ff, out_valid_in;
   logic [3*CW-1:0]               color_ff, color_in;
   logic                          out_flat_ff, out_flat_in;

   logic                          out_free;
   logic                          load;
   logic                          div_step;
   logic                          write_out;
   logic [hpc_pkg::NUM_W-1:0]     num;
   logic [RW:0]                   trial;
   logic [RW:0]                   diff;
   logic                          fits;
   logic [SW-1:0]                 seg;
   logic [CW-1:0]                 weight;
   logic [2:0]                    pt_lo, pt_hi;

   assign out_free = ~out_valid_ff | rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hpc_pkg::BK_IDLE: begin
            if (head_valid) begin
               state_in = head_job.flat ? hpc_pkg::BK_DONE : hpc_pkg::BK_DIV;
            end
         end
         hpc_pkg::BK_DIV: begin
            if (step_ff == hpc_pkg::STEP_W'(QW - 1)) begin
               state_in = hpc_pkg::BK_DONE;
            end
         end
         hpc_pkg::BK_DONE: begin
            if (out_free) begin
               state_in = hpc_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = hpc_pkg::BK_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      load      = 1'b0;
      div_step  = 1'b0;
      write_out = 1'b0;
      case (state_ff)
         hpc_pkg::BK_IDLE: begin
            load = head_valid;
         end
         hpc_pkg::BK_DIV: begin
            div_step = 1'b1;
         end
         hpc_pkg::BK_DONE: begin
            write_out = out_free;
         end
         default: begin
         end
      endcase
   end

   assign pop = load;

   // dividend is 5*delta*256; quotient holds segment over weight
   assign num   = {1'b0, head_job.delta, 2'b00} + hpc_pkg::NUM_W'(head_job.delta);
   assign trial = {rem_ff, dq_ff[QW-1]};
   assign diff  = trial - {1'b0, range_ff};
   assign fits  = (trial >= {1'b0, range_ff});

   // divider registers, one quotient bit per step
   always_comb begin
      step_in  = step_ff;
      rem_in   = rem_ff;
      dq_in    = dq_ff;
      range_in = range_ff;
      flat_in  = flat_ff;
      if (load) begin
         step_in  = '0;
         range_in = head_job.range;
         flat_in  = head_job.flat;
         if (head_job.flat) begin
            rem_in = '0;
            dq_in  = '0;
         end else begin
            rem_in = {1'b0, num[hpc_pkg::NUM_W-1:3]};
            dq_in  = {num[2:0], {CW{1'b0}}};
         end
      end else if (div_step) begin
         step_in = step_ff + hpc_pkg::STEP_W'(1);
         rem_in  = fits ? diff[RW-1:0] : trial[RW-1:0];
         dq_in   = {dq_ff[QW-2:0], fits};
      end
   end

   // blend between the two ramp points around the segment
   assign seg    = dq_ff[QW-1:CW];
   assign weight = dq_ff[CW-1:0];
   assign pt_lo  = hpc_pkg::ramp_point(seg);
   assign pt_hi  = hpc_pkg::ramp_point(seg + SW'(1));

   always_comb begin
      color_in     = color_ff;
      out_flat_in  = out_flat_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      if (write_out) begin
         out_valid_in = 1'b1;
         out_flat_in  = flat_ff;
         color_in     = {hpc_pkg::blend(pt_lo[0], pt_hi[0], weight),
                         hpc_pkg::blend(pt_lo[1], pt_hi[1], weight),
                         hpc_pkg::blend(pt_lo[2], pt_hi[2], weight)};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hpc_pkg::BK_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      dq_ff       <= dq_in;
      range_ff    <= range_in;
      flat_ff     <= flat_in;
      color_ff    <= color_in;
      out_flat_ff <= out_flat_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = color_ff;
   assign rsp_tuser  = out_flat_ff;

endmodule
`default_nettype wire

// ----- design/heightmap_palette_colorizer.sv -----
// top level: clear and scan items update min/max at once; a map item is queued, loaded by
// the back part when it is idle, run through the 11-step restoring divider (skipped when
// the image is flat) and written to the output register once that is free; the back part
// takes a new map item only after the last one is through.
// clear and scan items are taken every cycle while the front queue has room.
// reset (synchronous, active high) sets min to 65536, max to 0 and empties queue and output.
`default_nettype none
module heightmap_palette_colorizer #(
   parameter int unsigned QueueDepth = hpc_pkg::QUEUE_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [hpc_pkg::SAMPLE_W-1:0]      req_tdata,   // sample
   input  wire logic [hpc_pkg::KIND_W-1:0]        req_tuser,   // req_type
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [3*hpc_pkg::COLOR_W-1:0]          rsp_tdata,   // red, green, blue
   output logic                                   rsp_tuser    // flat
);

   logic             queue_full;
   logic             push;
   hpc_pkg::job_type push_job;
   logic             pop;
   logic             head_valid;
   hpc_pkg::job_type head_job;

   // classification and min/max tracking
   hpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .job        (push_job)
   );

   // decoupling queue
   hpc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // division, blend and result register
   hpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire
